/* hdl/lnr_pkg.sv */
package lnr_pkg;

    // field widths
    localparam int VAL_W = 48;
    localparam int LO_W  = 32;
    localparam int HI_W  = 17;             // high half plus sign-extension carry
    localparam int UP_W  = 49;             // lattice term from the high half, signed
    localparam int BP_W  = 64;             // bound products and sums
    localparam int M_W   = 36;             // lattice coordinates
    localparam int C_W   = 56;             // corner sums
    localparam int S_W   = 48;             // seed
    localparam int HALF  = 24;             // split point of the back-step multiply
    localparam int N_CRN = 3;              // lattice corners tested per request
    localparam int SEL_W = $clog2(N_CRN);

    typedef logic signed [BP_W-1:0] t_bp;
    typedef logic signed [M_W-1:0]  t_m;
    typedef logic signed [C_W-1:0]  t_c;
    typedef logic signed [17:0]     t_k;
    typedef logic [S_W-1:0]         t_seed;
    typedef logic [C_W-17:0]        t_upc;
    typedef logic [SEL_W-1:0]       t_sel;

    // bound matrix
    localparam t_k K_LMAX = 18'sd33441;
    localparam t_k K_UMAX = 18'sd17549;
    localparam t_k K_LMIN = 18'sd46603;
    localparam t_k K_UMIN = 18'sd39761;

    // corner matrix
    localparam t_k K_C1L = 18'sd39761;
    localparam t_k K_C2L = 18'sd35098;
    localparam t_k K_C1U = 18'sd46603;
    localparam t_k K_C2U = 18'sd66882;

    localparam logic signed [47:0] LAT_OFFSET = 48'sd107048004364969;

    // per-corner offsets: (0,0), (1,0), (0,1)
    localparam t_c CAND_OFS [N_CRN] = '{56'sd0, -56'sd39761, 56'sd35098};
    localparam t_c UP_OFS   [N_CRN] = '{56'sd107048004364969,
                                        56'sd107048004411572,
                                        56'sd107048004431851};

    // two steps back
    localparam logic [S_W-1:0]  BACK2_MUL = 48'd254681119335897;
    localparam logic [S_W-1:0]  BACK2_ADD = 48'd120305458776662;
    localparam logic [HALF-1:0] B2_LO     = BACK2_MUL[HALF-1:0];
    localparam logic [HALF-1:0] B2_HI     = BACK2_MUL[S_W-1:HALF];

    typedef struct packed {
        logic            valid;
        logic [LO_W-1:0] lo;
        logic [HI_W-1:0] hi;
        t_m              m1;
        t_m              m2;
    } t_bnd;

    typedef struct packed {
        logic               valid;
        logic [LO_W-1:0]    lo;
        logic [HI_W-1:0]    hi;
        t_c [N_CRN-1:0]     cand;
        t_c [N_CRN-1:0]     up;
    } t_crn;

    typedef struct packed {
        logic  match;
        t_seed seed;
    } t_lane;

endpackage

/* hdl/lnr_bounds.sv */
// Stages 1-3: split, bound products, lattice coordinates.
module lnr_bounds (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [lnr_pkg::VAL_W-1:0]    i_value,
    output lnr_pkg::t_bnd                o_bnd
);

    logic [lnr_pkg::HI_W-1:0]        w_hi;
    logic signed [lnr_pkg::UP_W:0]   w_t;
    logic signed [lnr_pkg::UP_W:0]   w_t_sh;

    logic                            r1_v;
    logic [lnr_pkg::LO_W-1:0]        r1_lo;
    logic [lnr_pkg::HI_W-1:0]        r1_hi;
    logic signed [lnr_pkg::UP_W-1:0] r1_up;

    logic [46:0]                     w_lmin;
    logic [46:0]                     w_lmax;

    logic                            r2_v;
    logic [lnr_pkg::LO_W-1:0]        r2_lo;
    logic [lnr_pkg::HI_W-1:0]        r2_hi;
    lnr_pkg::t_bp                    r2_pa;
    lnr_pkg::t_bp                    r2_pb;
    lnr_pkg::t_bp                    r2_pc;
    lnr_pkg::t_bp                    r2_pd;

    lnr_pkg::t_bp                    w_s1;
    lnr_pkg::t_bp                    w_s2;
    lnr_pkg::t_bp                    w_sh1;
    lnr_pkg::t_bp                    w_sh2;
    lnr_pkg::t_m                     n_m1;
    lnr_pkg::t_m                     n_m2;

    logic                            r3_v;
    logic [lnr_pkg::LO_W-1:0]        r3_lo;
    logic [lnr_pkg::HI_W-1:0]        r3_hi;
    lnr_pkg::t_m                     r3_m1;
    lnr_pkg::t_m                     r3_m2;

    // high half gets the borrow back when the low word was negative
    assign w_hi   = {1'b0, i_value[lnr_pkg::VAL_W-1:lnr_pkg::LO_W]}
                  + lnr_pkg::HI_W'(i_value[lnr_pkg::LO_W-1]);
    assign w_t    = $signed({17'b0, w_hi, 16'b0}) - 50'(lnr_pkg::LAT_OFFSET);
    assign w_t_sh = w_t >>> 1;

    assign w_lmin = {r1_lo, 15'h0000};
    assign w_lmax = {r1_lo, 15'h7fff};

    assign w_s1  = r2_pb - r2_pa;
    assign w_s2  = r2_pc + r2_pd;
    assign w_sh1 = w_s1 >>> 30;
    assign w_sh2 = w_s2 >>> 31;
    assign n_m1  = lnr_pkg::t_m'(w_sh1) + lnr_pkg::t_m'(1);
    assign n_m2  = lnr_pkg::t_m'(w_sh2) + lnr_pkg::t_m'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lo <= i_value[lnr_pkg::LO_W-1:0];
            r1_hi <= w_hi;
            r1_up <= w_t_sh[lnr_pkg::UP_W-1:0];

            r2_lo <= r1_lo;
            r2_hi <= r1_hi;
            r2_pa <= lnr_pkg::t_bp'({17'b0, w_lmax}) * lnr_pkg::t_bp'(lnr_pkg::K_LMAX);
            r2_pb <= lnr_pkg::t_bp'(r1_up) * lnr_pkg::t_bp'(lnr_pkg::K_UMAX);
            r2_pc <= lnr_pkg::t_bp'({17'b0, w_lmin}) * lnr_pkg::t_bp'(lnr_pkg::K_LMIN);
            r2_pd <= lnr_pkg::t_bp'(r1_up) * lnr_pkg::t_bp'(lnr_pkg::K_UMIN);

            r3_lo <= r2_lo;
            r3_hi <= r2_hi;
            r3_m1 <= n_m1;
            r3_m2 <= n_m2;
        end
    end

    assign o_bnd.valid = r3_v;
    assign o_bnd.lo    = r3_lo;
    assign o_bnd.hi    = r3_hi;
    assign o_bnd.m1    = r3_m1;
    assign o_bnd.m2    = r3_m2;

endmodule

/* hdl/lnr_corner.sv */
// Stages 4-5: corner products, then candidate and upper sums per corner.
module lnr_corner (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  lnr_pkg::t_bnd  i_bnd,
    output lnr_pkg::t_crn  o_crn
);

    logic                     r4_v;
    logic [lnr_pkg::LO_W-1:0] r4_lo;
    logic [lnr_pkg::HI_W-1:0] r4_hi;
    lnr_pkg::t_c              r4_q1;
    lnr_pkg::t_c              r4_q2;
    lnr_pkg::t_c              r4_q3;
    lnr_pkg::t_c              r4_q4;

    lnr_pkg::t_c              w_cbase;
    lnr_pkg::t_c              w_ubase;

    logic                     r5_v;
    logic [lnr_pkg::LO_W-1:0] r5_lo;
    logic [lnr_pkg::HI_W-1:0] r5_hi;
    lnr_pkg::t_c              r5_cand [lnr_pkg::N_CRN];
    lnr_pkg::t_c              r5_up   [lnr_pkg::N_CRN];

    assign w_cbase = r4_q2 - r4_q1;
    assign w_ubase = r4_q3 + r4_q4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= i_bnd.valid;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_lo <= i_bnd.lo;
            r4_hi <= i_bnd.hi;
            r4_q1 <= lnr_pkg::t_c'(i_bnd.m1) * lnr_pkg::t_c'(lnr_pkg::K_C1L);
            r4_q2 <= lnr_pkg::t_c'(i_bnd.m2) * lnr_pkg::t_c'(lnr_pkg::K_C2L);
            r4_q3 <= lnr_pkg::t_c'(i_bnd.m1) * lnr_pkg::t_c'(lnr_pkg::K_C1U);
            r4_q4 <= lnr_pkg::t_c'(i_bnd.m2) * lnr_pkg::t_c'(lnr_pkg::K_C2U);

            r5_lo <= r4_lo;
            r5_hi <= r4_hi;
            for (int k = 0; k < lnr_pkg::N_CRN; k++) begin
                r5_cand[k] <= w_cbase + lnr_pkg::CAND_OFS[k];
                r5_up[k]   <= w_ubase + lnr_pkg::UP_OFS[k];
            end
        end
    end

    always_comb begin
        o_crn.valid = r5_v;
        o_crn.lo    = r5_lo;
        o_crn.hi    = r5_hi;
        for (int k = 0; k < lnr_pkg::N_CRN; k++) begin
            o_crn.cand[k] = r5_cand[k];
            o_crn.up[k]   = r5_up[k];
        end
    end

endmodule

/* hdl/lnr_back2.sv */
// Stages 6-7 for one corner: match test, then state pulled back two steps
// (mod 2^48 multiply as 24-bit partial products).
module lnr_back2 (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [lnr_pkg::LO_W-1:0] i_lo,
    input  logic [lnr_pkg::HI_W-1:0] i_hi,
    input  lnr_pkg::t_c              i_cand,
    input  lnr_pkg::t_c              i_up,
    output lnr_pkg::t_lane           o_lane
);

    logic                         w_match;
    logic [lnr_pkg::HALF-1:0]     w_alo;
    logic [lnr_pkg::HALF-1:0]     w_ahi;

    logic                         r6_m;
    logic [lnr_pkg::S_W-1:0]      r6_pp0;
    logic [lnr_pkg::HALF-1:0]     r6_pp1;
    logic [lnr_pkg::HALF-1:0]     r6_pp2;

    logic [lnr_pkg::HALF-1:0]     w_mid;
    lnr_pkg::t_seed               n_seed;

    logic                         r7_m;
    lnr_pkg::t_seed               r7_seed;

    // upper must equal the high half; candidate must be non-negative,
    // below 2^48, with bits 47:16 equal to the low half
    assign w_match = i_valid
                  && (i_up[lnr_pkg::C_W-1:16] == lnr_pkg::t_upc'(i_hi))
                  && (i_cand[lnr_pkg::C_W-1:lnr_pkg::S_W] == '0)
                  && (i_cand[lnr_pkg::S_W-1:16] == i_lo);

    assign w_alo = i_cand[lnr_pkg::HALF-1:0];
    assign w_ahi = i_cand[lnr_pkg::S_W-1:lnr_pkg::HALF];

    assign w_mid  = r6_pp1 + r6_pp2;
    assign n_seed = r6_pp0 + {w_mid, {lnr_pkg::HALF{1'b0}}} + lnr_pkg::BACK2_ADD;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_m <= 1'b0;
            r7_m <= 1'b0;
        end else if (i_en) begin
            r6_m <= w_match;
            r7_m <= r6_m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_pp0  <= lnr_pkg::t_seed'(w_alo) * lnr_pkg::t_seed'(lnr_pkg::B2_LO);
            r6_pp1  <= w_ahi * lnr_pkg::B2_LO;
            r6_pp2  <= w_alo * lnr_pkg::B2_HI;
            r7_seed <= n_seed;
        end
    end

    assign o_lane.match = r7_m;
    assign o_lane.seed  = r7_seed;

endmodule

/* hdl/lnr_emit.sv */
// Result serializer: holds the matches of one request, one result a cycle.
module lnr_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lnr_pkg::t_lane       i_lane [lnr_pkg::N_CRN],
    output logic                 o_ready,
    output logic                 o_strobe,
    output lnr_pkg::t_seed       o_seed,
    output logic                 o_last
);

    logic [lnr_pkg::N_CRN-1:0] r_mask;
    logic [lnr_pkg::N_CRN-1:0] n_mask;
    logic [lnr_pkg::N_CRN-1:0] w_rest;
    logic [lnr_pkg::N_CRN-1:0] w_in_mask;
    lnr_pkg::t_sel             w_sel;
    lnr_pkg::t_seed            r_seed [lnr_pkg::N_CRN];

    logic                      r_strobe;
    lnr_pkg::t_seed            r_out_seed;
    logic                      r_last;

    always_comb begin
        w_sel = '0;
        for (int k = lnr_pkg::N_CRN - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                w_sel = lnr_pkg::t_sel'(k);
            end
        end
        w_rest = r_mask & ~(lnr_pkg::N_CRN'(1) << w_sel);
        for (int k = 0; k < lnr_pkg::N_CRN; k++) begin
            w_in_mask[k] = i_lane[k].match;
        end
    end

    // free once at most the result now going out is left
    assign o_ready = (w_rest == '0);
    assign n_mask  = o_ready ? w_in_mask : w_rest;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_mask   <= n_mask;
            r_strobe <= |r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            for (int k = 0; k < lnr_pkg::N_CRN; k++) begin
                r_seed[k] <= i_lane[k].seed;
            end
        end
        r_out_seed <= r_seed[w_sel];
        r_last     <= (w_rest == '0);
    end

    assign o_strobe = r_strobe;
    assign o_seed   = r_out_seed;
    assign o_last   = r_last;

endmodule

/* hdl/lcg_next_long_reverser.sv */
// Channel   Signals                                   Direction  Handshake
// --------  ----------------------------------------  ---------  -----------------------
// request   start, i_observed_value[47:0]             in         taken when start & !busy
// result    o_strobe, o_recovered_seed[47:0],         out        one strobe per result,
//           o_last_flag                                          no backpressure
//
// One request per cycle while each request yields at most one result; a request
// with n matches (up to three) holds the single result port until all n are out, and
// busy stays high while it has more than one match left in the serializer.
// A request passes the bounds, corner and lane stages, then the serializer mask and result registers.
// Reset (i_rst_n low, synchronous) clears every stage valid and the result strobe.
// While busy is high the whole pipeline holds; nothing is lost or repeated.
// A request with no matching corner produces no result strobe; o_last_flag is high whenever no strobe is out.
module lcg_next_long_reverser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic [lnr_pkg::VAL_W-1:0] i_observed_value,
    output logic                      busy,
    output logic                      o_strobe,
    output logic [lnr_pkg::S_W-1:0]   o_recovered_seed,
    output logic                      o_last_flag
);

    logic           w_ready;     // pipeline advance, from the serializer
    logic           w_go;        // request taken this cycle
    lnr_pkg::t_bnd  w_bnd;
    lnr_pkg::t_crn  w_crn;
    lnr_pkg::t_lane w_lane [lnr_pkg::N_CRN];

    assign busy = !w_ready;
    assign w_go = start && w_ready;

    // stages 1-3: split, borrow fix, lattice bounds, coordinates m1/m2
    lnr_bounds u_bounds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ready),
        .i_valid (w_go),
        .i_value (i_observed_value),
        .o_bnd   (w_bnd)
    );

    // stages 4-5: the three corners share one set of products
    lnr_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ready),
        .i_bnd   (w_bnd),
        .o_crn   (w_crn)
    );

    // stages 6-7: one lane per corner, in corner order (0,0), (1,0), (0,1)
    for (genvar g = 0; g < lnr_pkg::N_CRN; g++) begin : g_lane
        lnr_back2 u_back2 (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_ready),
            .i_valid (w_crn.valid),
            .i_lo    (w_crn.lo),
            .i_hi    (w_crn.hi),
            .i_cand  (w_crn.cand[g]),
            .i_up    (w_crn.up[g]),
            .o_lane  (w_lane[g])
        );
    end

    // serializer: lowest corner first, last flag on the final match
    lnr_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_lane   (w_lane),
        .o_ready  (w_ready),
        .o_strobe (o_strobe),
        .o_seed   (o_recovered_seed),
        .o_last   (o_last_flag)
    );

endmodule
